// File: rtl/i2cws_pkg.sv
// ----------------------------------------------------------------------------
// i2cws_pkg
// shared command codes, job kinds and link structs for the i2c write
// pin sequencer
// ----------------------------------------------------------------------------
package i2cws_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SINGLE = 2'd1;
    localparam logic [1:0] CMD_STREAM = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    localparam logic [2:0] JOB_START  = 3'd0;
    localparam logic [2:0] JOB_SINGLE = 3'd1;
    localparam logic [2:0] JOB_FLAT   = 3'd2;
    localparam logic [2:0] JOB_BITS   = 3'd3;
    localparam logic [2:0] JOB_STOP   = 3'd4;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hff;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/i2cws_front.sv
// ----------------------------------------------------------------------------
// i2cws_front
// accepts commands and turns each into a classified job for the queue
// ----------------------------------------------------------------------------
module i2cws_front
    import i2cws_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic [7:0] slave_address,
    input  q_status_t  q_status,
    output logic       push,
    output job_t       push_job
);

    logic flat_byte;

    assign flat_byte = (s_tdata == BYTE_ZERO) || (s_tdata == BYTE_ONES);
    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && !q_status.full;

    always_comb
    begin
        push_job.data = s_tdata;
        unique case (s_tuser)
            CMD_START:
            begin
                push_job.kind = JOB_START;
                push_job.data = slave_address;
            end
            CMD_SINGLE: push_job.kind = JOB_SINGLE;
            CMD_STREAM: push_job.kind = flat_byte ? JOB_FLAT : JOB_BITS;
            CMD_STOP:   push_job.kind = JOB_STOP;
            default:    push_job.kind = JOB_STOP;
        endcase
    end

endmodule

// File: rtl/i2cws_fifo.sv
// ----------------------------------------------------------------------------
// i2cws_fifo
// small job queue between the command front and the pin sequencer
// ----------------------------------------------------------------------------
module i2cws_fifo
    import i2cws_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_job        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/i2cws_back.sv
// ----------------------------------------------------------------------------
// i2cws_back
// pin sequencer: plays one job as a run of sda/scl writes, one per cycle
// unless m_axis is stalled, into an output register
// ----------------------------------------------------------------------------
module i2cws_back
    import i2cws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       job,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_BITS = 3'd2;
    localparam logic [2:0] S_FLAT = 3'd3;
    localparam logic [2:0] S_ACK  = 3'd4;
    localparam logic [2:0] S_STOP = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] bcnt_reg, bcnt_next;
    logic [7:0] sh_reg, sh_next;
    logic       lb_reg, lb_next;
    logic       single_reg, single_next;
    logic       scl_now_reg, scl_now_next;
    logic       driving_reg, driving_next;
    logic       ovalid_reg, ovalid_next;
    logic       osda_reg, oscl_reg, odrv_reg, olast_reg;

    logic emit, done, load;
    logic w_sda, w_scl, w_drv, w_last;

    assign emit = (state_reg != S_IDLE) && (!ovalid_reg || m_tready);

    // pin levels of the write made this cycle
    always_comb
    begin
        w_sda  = sh_reg[7];
        w_scl  = 1'b0;
        w_drv  = driving_reg;
        w_last = 1'b0;
        unique case (state_reg)
            S_PRE:
            begin
                w_sda = (cnt_reg == 2'd0);
                w_scl = (cnt_reg != 2'd2);
                w_drv = 1'b1;
            end
            S_BITS: w_scl = (cnt_reg == 2'd1);
            S_FLAT: w_scl = (cnt_reg == 2'd1);
            S_ACK:
            begin
                w_sda  = (cnt_reg == 2'd2) && single_reg && lb_reg;
                w_scl  = (cnt_reg == 2'd1);
                w_last = (cnt_reg == 2'd2);
            end
            S_STOP:
            begin
                w_sda  = cnt_reg[1];
                w_scl  = (cnt_reg == 2'd0) ? scl_now_reg : 1'b1;
                w_drv  = (cnt_reg == 2'd3) ? 1'b0 : driving_reg;
                w_last = (cnt_reg == 2'd3);
            end
            default:
            begin
                w_sda = sh_reg[7];
            end
        endcase
    end

    assign done = emit && w_last;
    assign load = ((state_reg == S_IDLE) || done) && !q_status.empty;
    assign pop  = load;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bcnt_next    = bcnt_reg;
        sh_next      = sh_reg;
        lb_next      = lb_reg;
        single_next  = single_reg;
        scl_now_next = scl_now_reg;
        driving_next = driving_reg;
        ovalid_next  = ovalid_reg && !m_tready;

        if (emit)
        begin
            ovalid_next  = 1'b1;
            scl_now_next = w_scl;
            driving_next = w_drv;
            unique case (state_reg)
                S_PRE:
                begin
                    if (cnt_reg == 2'd2)
                    begin
                        state_next = S_BITS;
                        cnt_next   = 2'd0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                S_BITS:
                begin
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_next  = 2'd0;
                        sh_next   = {sh_reg[6:0], 1'b0};
                        bcnt_next = bcnt_reg + 3'd1;
                        if (bcnt_reg == LAST_BIT)
                        begin
                            lb_next    = sh_reg[7];
                            state_next = S_ACK;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                S_FLAT:
                begin
                    if (cnt_reg == 2'd2)
                    begin
                        bcnt_next = bcnt_reg + 3'd1;
                        if (bcnt_reg == LAST_BIT)
                        begin
                            cnt_next   = 2'd0;
                            state_next = S_ACK;
                        end
                        else
                        begin
                            cnt_next = 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                S_ACK, S_STOP:
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
            if (done)
            begin
                state_next = S_IDLE;
            end
        end

        if (load)
        begin
            cnt_next    = 2'd0;
            bcnt_next   = 3'd0;
            sh_next     = job.data;
            single_next = (job.kind == JOB_START) || (job.kind == JOB_SINGLE);
            unique case (job.kind)
                JOB_START:  state_next = S_PRE;
                JOB_SINGLE: state_next = S_BITS;
                JOB_FLAT:   state_next = S_FLAT;
                JOB_BITS:   state_next = S_BITS;
                default:    state_next = S_STOP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 2'd0;
            bcnt_reg    <= 3'd0;
            single_reg  <= 1'b0;
            lb_reg      <= 1'b0;
            scl_now_reg <= 1'b1;
            driving_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bcnt_reg    <= bcnt_next;
            single_reg  <= single_next;
            lb_reg      <= lb_next;
            scl_now_reg <= scl_now_next;
            driving_reg <= driving_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        if (emit)
        begin
            osda_reg  <= w_sda;
            oscl_reg  <= w_scl;
            odrv_reg  <= w_drv;
            olast_reg <= w_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, odrv_reg, oscl_reg, osda_reg};
    assign m_tlast  = olast_reg;

endmodule

// File: rtl/i2c_master_write_pin_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_write_pin_sequencer_core
// write-only i2c master that expands commands into sda/scl pin writes
//
//   channel   direction  payload
//   s_axis    in         tuser: cmd, tdata: data_byte
//   m_axis    out        tdata: sda_level, scl_level, lines_driven; tlast
//   apb       in         slave_address at byte address 0
//
// one pin write leaves the sequencer per cycle while m_axis is not stalled; a
// stream byte of 0x00 or 0xff takes a shorter flat path than other bytes. a
// command queued before the previous one finishes is loaded with that one's
// last write, else it passes through the queue registers and the state
// register before its first write. reset is immediate, with no clearing pass.
// a stalled m_axis holds the sequencer while the queue keeps taking commands until full.
// ----------------------------------------------------------------------------
module i2c_master_write_pin_sequencer_core
    import i2cws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] sda_level, [1] scl_level, [2] lines_driven
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] slave_address_reg;
    logic       cfg_write;
    q_status_t  q_status;
    logic       push, pop;
    job_t       push_job, pop_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {24'd0, slave_address_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            slave_address_reg <= pwdata[7:0];
        end
    end

    i2cws_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .slave_address (slave_address_reg),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    i2cws_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    i2cws_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (pop_job),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // the last write of a command is either a clock-low write or the stop release
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[1] || (m_tdata[0] && !m_tdata[2]))
        else $error("final write has clock high without stop release");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job taken from empty queue");

endmodule
